[sv/ptu_pkg.sv]
// ----------------------------------------------------------------------------
// ptu_pkg
// Shared types, constants and helper functions for the pool test posterior
// update block.
// ----------------------------------------------------------------------------
package ptu_pkg;

    // Lattice geometry.
    localparam int SUBJECTS    = 4;
    localparam int VARIANTS    = 2;
    localparam int STATE_COUNT = 256;
    localparam int STATE_W     = $clog2(STATE_COUNT);
    localparam int LAT_W       = SUBJECTS * VARIANTS;
    localparam int EXT_W       = (STATE_W > LAT_W) ? STATE_W : LAT_W;

    // Fixed field widths.
    localparam int ACTION_W    = 2;
    localparam int INDEX_W     = 8;
    localparam int POOL_W      = 4;
    localparam int OBS_W       = 2;
    localparam int POOL_EXT_W  = (SUBJECTS > POOL_W) ? SUBJECTS : POOL_W;
    localparam int OBS_EXT_W   = (VARIANTS > OBS_W) ? VARIANTS : OBS_W;

    // Arithmetic widths.
    localparam int PROB_W      = 32;
    localparam int SUM_W       = 40;
    localparam int REM_W       = SUM_W + 1;
    localparam int QBIT_W      = $clog2(PROB_W);
    localparam int STEP_W      = (VARIANTS > 1) ? $clog2(VARIANTS) : 1;
    localparam int MISS_W      = $clog2(VARIANTS + 1);

    // Configuration port.
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam logic [0:0] REG_MISMATCH = 1'b0;
    localparam logic [0:0] REG_MATCH    = 1'b1;
    localparam logic [PROB_W-1:0] MISMATCH_RESET = 32'd21474836;
    localparam logic [PROB_W-1:0] MATCH_RESET    = 32'd4230542622;

    // Request actions.
    localparam logic [ACTION_W-1:0] ACT_LOAD = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TEST = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ = 2'd2;

    // Result status codes.
    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_ZERO = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ_WAIT,
        S_SCALE_RD,
        S_SCALE_CAP,
        S_SCALE_MUL,
        S_SCALE_WR,
        S_SUM_CHK,
        S_NORM_RD,
        S_NORM_CAP,
        S_NORM_DIV,
        S_NORM_WR
    } t_state;

    typedef enum logic [2:0] {
        ALU_NOP,
        ALU_MUL,
        ALU_ACC,
        ALU_GE,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        t_alu_op           op;
        logic [PROB_W-1:0] a;
        logic [PROB_W-1:0] b;
        logic [REM_W-1:0]  rem;
        logic [SUM_W-1:0]  wide;
    } t_alu_req;

    typedef struct packed {
        logic [PROB_W-1:0] prod;
        logic [REM_W-1:0]  wide;
        logic              flag;
    } t_alu_rsp;

    // Expected per-variant response of one lattice state for a pool.
    function automatic logic [VARIANTS-1:0] expected_response(
        input logic [STATE_W-1:0] st,
        input logic [POOL_W-1:0]  pool
    );
        logic [EXT_W-1:0]      ext;
        logic [POOL_EXT_W-1:0] pe;
        logic [VARIANTS-1:0]   resp;
        ext = EXT_W'(st);
        pe  = POOL_EXT_W'(pool);
        for (int v = 0; v < VARIANTS; v++) begin
            resp[v] = 1'b1;
            for (int l = 0; l < SUBJECTS; l++) begin
                if (pe[l] && !ext[l*VARIANTS+v]) begin
                    resp[v] = 1'b0;
                end
            end
        end
        return resp;
    endfunction

    // Number of variants where expected and observed differ.
    function automatic logic [MISS_W-1:0] miss_count(
        input logic [VARIANTS-1:0] resp,
        input logic [OBS_W-1:0]    obs
    );
        logic [OBS_EXT_W-1:0] oe;
        logic [VARIANTS-1:0]  diff;
        logic [MISS_W-1:0]    n;
        oe   = OBS_EXT_W'(obs);
        diff = resp ^ oe[VARIANTS-1:0];
        n    = '0;
        for (int v = 0; v < VARIANTS; v++) begin
            n = n + MISS_W'(diff[v]);
        end
        return n;
    endfunction

endpackage

[sv/ptu_table_ram.sv]
// ----------------------------------------------------------------------------
// ptu_table_ram
// Posterior table storage: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
module ptu_table_ram (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [ptu_pkg::STATE_W-1:0] i_waddr,
    input  logic [ptu_pkg::PROB_W-1:0]  i_wdata,
    input  logic                        i_re,
    input  logic [ptu_pkg::STATE_W-1:0] i_raddr,
    output logic [ptu_pkg::PROB_W-1:0]  o_rdata
);
    import ptu_pkg::*;

    logic [PROB_W-1:0] r_mem [STATE_COUNT];
    logic [PROB_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/ptu_alu.sv]
// ----------------------------------------------------------------------------
// ptu_alu
// Shared arithmetic unit: Q0.32 multiply, saturating accumulate, compare and
// one restoring division step.
// ----------------------------------------------------------------------------
module ptu_alu (
    input  ptu_pkg::t_alu_req i_req,
    output ptu_pkg::t_alu_rsp o_rsp
);
    import ptu_pkg::*;

    logic [2*PROB_W-1:0] prod;
    logic [REM_W-1:0]    acc;
    logic [REM_W-1:0]    trial;
    logic [REM_W:0]      diff;

    always_comb begin
        prod  = '0;
        acc   = '0;
        trial = '0;
        diff  = '0;
        o_rsp = '0;
        case (i_req.op)
            ALU_MUL: begin
                prod       = i_req.a * i_req.b;
                o_rsp.prod = prod[2*PROB_W-1:PROB_W];
            end
            ALU_ACC: begin
                acc = {1'b0, i_req.wide} + REM_W'(i_req.a);
                // Saturate the running total at its full scale.
                o_rsp.wide = acc[SUM_W] ? {1'b0, {SUM_W{1'b1}}} : acc;
            end
            ALU_GE: begin
                o_rsp.flag = (SUM_W'(i_req.a) >= i_req.wide);
            end
            ALU_DIV: begin
                trial = {i_req.rem[REM_W-2:0], 1'b0};
                diff  = {1'b0, trial} - {2'b00, i_req.wide};
                if (!diff[REM_W]) begin
                    o_rsp.wide = diff[REM_W-1:0];
                    o_rsp.flag = 1'b1;
                end else begin
                    o_rsp.wide = trial;
                end
            end
            default: begin
                o_rsp = '0;
            end
        endcase
    end

endmodule

[sv/pool_test_posterior_update.sv]
// ----------------------------------------------------------------------------
// pool_test_posterior_update
// Bayesian group testing posterior update over a lattice of subject/variant
// states, with a shared arithmetic unit under a small sequencer.
// ----------------------------------------------------------------------------
// The block holds one unsigned Q0.32 probability for each of the 256 lattice
// states in an on-chip table. A load request writes one entry and a read
// request returns one entry; every request, whatever its action, produces
// exactly one result, and result fields that do not apply are zero. A test
// request walks the table twice through one shared arithmetic unit: the first
// pass scales each entry by the mismatch weight once per disagreeing variant
// and then by the match weight once per agreeing variant (truncating each
// product), writing it back and adding it into a 40-bit saturating total;
// the second pass divides each entry by that total with a restoring divider
// that retires one quotient bit per cycle. The input is ready only while the
// sequencer is idle and the result register is free. Each entry's division
// runs 32 restoring steps; a test whose total is zero stops after the first
// pass, reports status 1 and leaves the scaled, unnormalized table in place.
// The table is not cleared at reset: entries must be loaded before they are
// read or tested. The weights are written through the APB-style port,
// mismatch weight at byte address 0 and match weight at byte address 4; they
// must be written only while the block is idle, which the block itself does
// not enforce.
// ----------------------------------------------------------------------------
module pool_test_posterior_update (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Request channel.
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [ptu_pkg::ACTION_W-1:0] i_action,
    input  logic [ptu_pkg::INDEX_W-1:0]  i_state_index,
    input  logic [ptu_pkg::PROB_W-1:0]   i_prob_value,
    input  logic [ptu_pkg::POOL_W-1:0]   i_pool_mask,
    input  logic [ptu_pkg::OBS_W-1:0]    i_observed_response,
    // Result channel.
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [ptu_pkg::PROB_W-1:0]   o_prob_out,
    output logic                         o_status,
    // Configuration port.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ptu_pkg::PADDR_W-1:0]  paddr,
    input  logic [ptu_pkg::PDATA_W-1:0]  pwdata,
    output logic [ptu_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import ptu_pkg::*;

    // Sequencer and datapath registers.
    t_state              r_state,     n_state;
    logic [STATE_W-1:0]  r_idx,       n_idx;
    logic [STEP_W-1:0]   r_step,      n_step;
    logic [QBIT_W-1:0]   r_bit,       n_bit;
    logic [MISS_W-1:0]   r_miss,      n_miss;
    logic [POOL_W-1:0]   r_pool,      n_pool;
    logic [OBS_W-1:0]    r_obs,       n_obs;
    logic [PROB_W-1:0]   r_acc,       n_acc;
    logic [SUM_W-1:0]    r_sum,       n_sum;
    logic [REM_W-1:0]    r_rem,       n_rem;
    logic [PROB_W-1:0]   r_quot,      n_quot;
    logic                r_sat,       n_sat;
    logic                r_rd_ok,     n_rd_ok;
    logic                r_out_valid, n_out_valid;
    logic [PROB_W-1:0]   r_prob_out,  n_prob_out;
    logic                r_status,    n_status;
    logic [PROB_W-1:0]   r_mis_w;
    logic [PROB_W-1:0]   r_mat_w;

    // Table port controls.
    logic                mem_we;
    logic [STATE_W-1:0]  mem_waddr;
    logic [PROB_W-1:0]   mem_wdata;
    logic                mem_re;
    logic [STATE_W-1:0]  mem_raddr;
    logic [PROB_W-1:0]   mem_rdata;

    t_alu_req            alu_req;
    t_alu_rsp            alu_rsp;

    logic                in_acc;
    logic                in_range;
    logic                last_idx;
    logic                cfg_wr;
    logic [0:0]          cfg_sel;

    ptu_table_ram u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ptu_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    // ------------------------------------------------------------------
    // Configuration registers. Writes complete in the access phase; the
    // port never inserts wait states.
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_sel = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mis_w <= MISMATCH_RESET;
            r_mat_w <= MATCH_RESET;
        end else if (cfg_wr) begin
            case (cfg_sel)
                REG_MISMATCH: r_mis_w <= pwdata;
                REG_MATCH:    r_mat_w <= pwdata;
                default:      r_mis_w <= r_mis_w;
            endcase
        end
    end

    always_comb begin
        case (cfg_sel)
            REG_MISMATCH: prdata = r_mis_w;
            REG_MATCH:    prdata = r_mat_w;
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake. A new request is taken only when the sequencer is idle
    // and the result register is empty or being emptied in this cycle.
    // ------------------------------------------------------------------
    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_acc      = i_in_valid && o_in_ready;
    assign in_range    = (int'(i_state_index) < STATE_COUNT);
    assign last_idx    = (r_idx == STATE_W'(STATE_COUNT - 1));

    assign o_out_valid = r_out_valid;
    assign o_prob_out  = r_prob_out;
    assign o_status    = r_status;

    // ------------------------------------------------------------------
    // Sequencer: next state, datapath updates and table accesses.
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_step      = r_step;
        n_bit       = r_bit;
        n_miss      = r_miss;
        n_pool      = r_pool;
        n_obs       = r_obs;
        n_acc       = r_acc;
        n_sum       = r_sum;
        n_rem       = r_rem;
        n_quot      = r_quot;
        n_sat       = r_sat;
        n_rd_ok     = r_rd_ok;
        n_out_valid = r_out_valid && !i_out_ready;
        n_prob_out  = r_prob_out;
        n_status    = r_status;

        mem_we      = 1'b0;
        mem_waddr   = r_idx;
        mem_wdata   = r_acc;
        mem_re      = 1'b0;
        mem_raddr   = r_idx;

        alu_req     = '0;
        alu_req.op  = ALU_NOP;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_action)
                        ACT_LOAD: begin
                            mem_we      = in_range;
                            mem_waddr   = STATE_W'(i_state_index);
                            mem_wdata   = i_prob_value;
                            n_out_valid = 1'b1;
                            n_prob_out  = '0;
                            n_status    = STAT_OK;
                        end
                        ACT_TEST: begin
                            n_pool  = i_pool_mask;
                            n_obs   = i_observed_response;
                            n_idx   = '0;
                            n_sum   = '0;
                            n_state = S_SCALE_RD;
                        end
                        ACT_READ: begin
                            mem_re    = 1'b1;
                            mem_raddr = STATE_W'(i_state_index);
                            n_rd_ok   = in_range;
                            n_state   = S_READ_WAIT;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_prob_out  = '0;
                            n_status    = STAT_OK;
                        end
                    endcase
                end
            end
            S_READ_WAIT: begin
                n_out_valid = 1'b1;
                n_prob_out  = r_rd_ok ? mem_rdata : '0;
                n_status    = STAT_OK;
                n_state     = S_IDLE;
            end
            S_SCALE_RD: begin
                mem_re  = 1'b1;
                n_state = S_SCALE_CAP;
            end
            S_SCALE_CAP: begin
                n_acc   = mem_rdata;
                n_miss  = miss_count(expected_response(r_idx, r_pool), r_obs);
                n_step  = '0;
                n_state = S_SCALE_MUL;
            end
            S_SCALE_MUL: begin
                // Mismatch factors are applied first, then match factors.
                alu_req.op = ALU_MUL;
                alu_req.a  = r_acc;
                alu_req.b  = (r_step < r_miss) ? r_mis_w : r_mat_w;
                n_acc      = alu_rsp.prod;
                if (r_step == STEP_W'(VARIANTS - 1)) begin
                    n_state = S_SCALE_WR;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_SCALE_WR: begin
                mem_we       = 1'b1;
                alu_req.op   = ALU_ACC;
                alu_req.a    = r_acc;
                alu_req.wide = r_sum;
                n_sum        = alu_rsp.wide[SUM_W-1:0];
                if (last_idx) begin
                    n_state = S_SUM_CHK;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SCALE_RD;
                end
            end
            S_SUM_CHK: begin
                if (r_sum == '0) begin
                    n_out_valid = 1'b1;
                    n_prob_out  = '0;
                    n_status    = STAT_ZERO;
                    n_state     = S_IDLE;
                end else begin
                    n_idx   = '0;
                    n_state = S_NORM_RD;
                end
            end
            S_NORM_RD: begin
                mem_re  = 1'b1;
                n_state = S_NORM_CAP;
            end
            S_NORM_CAP: begin
                // An entry equal to the total would give a quotient of one,
                // which does not fit and saturates.
                alu_req.op   = ALU_GE;
                alu_req.a    = mem_rdata;
                alu_req.wide = r_sum;
                n_sat        = alu_rsp.flag;
                n_rem        = REM_W'(mem_rdata);
                n_quot       = '0;
                n_bit        = '0;
                n_state      = S_NORM_DIV;
            end
            S_NORM_DIV: begin
                alu_req.op   = ALU_DIV;
                alu_req.rem  = r_rem;
                alu_req.wide = r_sum;
                n_rem        = alu_rsp.wide;
                n_quot       = {r_quot[PROB_W-2:0], alu_rsp.flag};
                if (r_bit == QBIT_W'(PROB_W - 1)) begin
                    n_state = S_NORM_WR;
                end else begin
                    n_bit = r_bit + 1'b1;
                end
            end
            S_NORM_WR: begin
                mem_we    = 1'b1;
                mem_wdata = r_sat ? {PROB_W{1'b1}} : r_quot;
                if (last_idx) begin
                    n_out_valid = 1'b1;
                    n_prob_out  = '0;
                    n_status    = STAT_OK;
                    n_state     = S_IDLE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_NORM_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and the running total are cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_sum       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_sum       <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_step     <= n_step;
        r_bit      <= n_bit;
        r_miss     <= n_miss;
        r_pool     <= n_pool;
        r_obs      <= n_obs;
        r_acc      <= n_acc;
        r_rem      <= n_rem;
        r_quot     <= n_quot;
        r_sat      <= n_sat;
        r_rd_ok    <= n_rd_ok;
        r_prob_out <= n_prob_out;
        r_status   <= n_status;
    end

endmodule

[tb/ptu_posterior_checker.sv]
// ----------------------------------------------------------------------------
// ptu_posterior_checker
// Watches the request, result and configuration ports of the pool test
// posterior update block, predicts every result and compares it field by
// field.
// ----------------------------------------------------------------------------
module ptu_posterior_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic [ptu_pkg::ACTION_W-1:0] i_action,
    input  logic [ptu_pkg::INDEX_W-1:0]  i_state_index,
    input  logic [ptu_pkg::PROB_W-1:0]   i_prob_value,
    input  logic [ptu_pkg::POOL_W-1:0]   i_pool_mask,
    input  logic [ptu_pkg::OBS_W-1:0]    i_observed_response,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [ptu_pkg::PROB_W-1:0]   i_prob_out,
    input  logic                         i_status,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [ptu_pkg::PADDR_W-1:0]  i_paddr,
    input  logic [ptu_pkg::PDATA_W-1:0]  i_pwdata,
    input  logic                         i_pready,
    output int                           o_pending,
    output int                           o_err_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import ptu_pkg::*;

    typedef struct packed {
        logic [PROB_W-1:0] prob;
        logic              status;
    } t_outcome;

    localparam logic [63:0] TOTAL_CAP = (64'd1 << SUM_W) - 64'd1;

    logic [PROB_W-1:0] post_mem [STATE_COUNT];
    logic [PROB_W-1:0] miss_weight = MISMATCH_RESET;
    logic [PROB_W-1:0] hit_weight  = MATCH_RESET;
    t_outcome          outcome_q [$];
    int                errors = 0;

    // Q0.32 product, truncated.
    function automatic logic [PROB_W-1:0] q32_scale(
        input logic [PROB_W-1:0] a,
        input logic [PROB_W-1:0] b
    );
        logic [63:0] prod;
        prod = 64'(a) * 64'(b);
        return prod[63:32];
    endfunction

    // A variant reads positive for a state when the state holds every bit
    // that the pooled subjects select for that variant.
    function automatic logic [VARIANTS-1:0] lattice_response(
        input int unsigned       st,
        input logic [POOL_W-1:0] pool
    );
        logic [VARIANTS-1:0] resp;
        int unsigned         need;
        for (int v = 0; v < VARIANTS; v++) begin
            need = 0;
            for (int l = 0; l < SUBJECTS; l++) begin
                if (pool[l]) begin
                    need |= 32'd1 << (l * VARIANTS + v);
                end
            end
            resp[v] = ((st & need) == need);
        end
        return resp;
    endfunction

    // Scales the whole table by the test likelihood, then normalizes it unless the total is zero.
    function automatic logic apply_test(
        input logic [POOL_W-1:0] pool,
        input logic [OBS_W-1:0]  obs
    );
        logic [63:0]         acc;
        logic [63:0]         quot;
        logic [PROB_W-1:0]   p;
        logic [VARIANTS-1:0] diff;
        int                  misses;
        acc = '0;
        for (int st = 0; st < STATE_COUNT; st++) begin
            diff   = lattice_response(st, pool) ^ obs[VARIANTS-1:0];
            misses = $countones(diff);
            p      = post_mem[st];
            for (int i = 0; i < VARIANTS; i++) begin
                p = q32_scale(p, (i < misses) ? miss_weight : hit_weight);
            end
            post_mem[st] = p;
            acc += 64'(p);
            if (acc > TOTAL_CAP) begin
                acc = TOTAL_CAP;
            end
        end
        if (acc == 0) begin
            return STAT_ZERO;
        end
        for (int st = 0; st < STATE_COUNT; st++) begin
            quot = {post_mem[st], 32'h0} / acc;
            post_mem[st] = (quot > 64'hFFFF_FFFF) ? '1 : quot[PROB_W-1:0];
        end
        return STAT_OK;
    endfunction

    function automatic t_outcome predict_outcome(
        input logic [ACTION_W-1:0] act,
        input logic [INDEX_W-1:0]  idx,
        input logic [PROB_W-1:0]   val,
        input logic [POOL_W-1:0]   pool,
        input logic [OBS_W-1:0]    obs
    );
        t_outcome res;
        res        = '0;
        res.status = STAT_OK;
        case (act)
            ACT_LOAD: begin
                if (idx < STATE_COUNT) begin
                    post_mem[idx] = val;
                end
            end
            ACT_TEST: begin
                res.status = apply_test(pool, obs);
            end
            ACT_READ: begin
                if (idx < STATE_COUNT) begin
                    res.prob = post_mem[idx];
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // Results are compared before the request of the same edge is predicted,
    // since a result accepted on that edge always belongs to an older request.
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            miss_weight = MISMATCH_RESET;
            hit_weight  = MATCH_RESET;
            outcome_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[2])
                    REG_MISMATCH: miss_weight = i_pwdata;
                    REG_MATCH:    hit_weight  = i_pwdata;
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (outcome_q.size() == 0) begin
                    errors++;
                    $error("result with no request outstanding: prob_out %h, status %b",
                           i_prob_out, i_status);
                end else begin
                    want = outcome_q.pop_front();
                    if (i_prob_out !== want.prob) begin
                        errors++;
                        $error("prob_out: expected %h, actual %h", want.prob, i_prob_out);
                    end
                    if (i_status !== want.status) begin
                        errors++;
                        $error("status: expected %b, actual %b", want.status, i_status);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                outcome_q.push_back(predict_outcome(i_action, i_state_index, i_prob_value,
                                                    i_pool_mask, i_observed_response));
            end
        end
        o_pending   <= outcome_q.size();
        o_err_count <= errors;
    end

endmodule

[tb/pool_test_posterior_update_tb.sv]
// ----------------------------------------------------------------------------
// pool_test_posterior_update_tb
// Drives load, read and test requests into the posterior update block under
// several weight settings and idling patterns; a checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module pool_test_posterior_update_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ptu_pkg::*;

    // The fourth action code is unused by the block; it must change nothing.
    localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

    localparam logic [PADDR_W-1:0] ADDR_MISMATCH = {REG_MISMATCH, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_MATCH    = {REG_MATCH, 2'b00};

    // A full test moves nothing on either channel while it walks the table twice,
    // so the watchdog limit is set well above the length of a test.
    localparam int WATCHDOG_LIMIT = 60000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 100;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [ACTION_W-1:0] i_action;
    logic [INDEX_W-1:0]  i_state_index;
    logic [PROB_W-1:0]   i_prob_value;
    logic [POOL_W-1:0]   i_pool_mask;
    logic [OBS_W-1:0]    i_observed_response;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [PROB_W-1:0]   o_prob_out;
    logic                o_status;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    int pending;
    int err_count;

    // Idling controls. The sender percentage is used only by the stimulus
    // process; the stall percentage and the hold flag are read by the result
    // sink, so they change by nonblocking assignment at a clock edge.
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit hold_armed   = 1'b0;

    pool_test_posterior_update dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_action            (i_action),
        .i_state_index       (i_state_index),
        .i_prob_value        (i_prob_value),
        .i_pool_mask         (i_pool_mask),
        .i_observed_response (i_observed_response),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_prob_out          (o_prob_out),
        .o_status            (o_status),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    ptu_posterior_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_in_ready          (o_in_ready),
        .i_action            (i_action),
        .i_state_index       (i_state_index),
        .i_prob_value        (i_prob_value),
        .i_pool_mask         (i_pool_mask),
        .i_observed_response (i_observed_response),
        .i_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .i_prob_out          (o_prob_out),
        .i_status            (o_status),
        .i_psel              (psel),
        .i_penable           (penable),
        .i_pwrite            (pwrite),
        .i_paddr             (paddr),
        .i_pwdata            (pwdata),
        .i_pready            (pready),
        .o_pending           (pending),
        .o_err_count         (err_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Result sink. Outside the one long hold-off, ready is drawn every cycle
    // from the current stall percentage.
    initial begin : result_sink
        int held;
        held = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_armed && held < RX_HOLD_CYCLES) begin
                i_out_ready <= 1'b0;
                held++;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves a request or a
    // result, and ends the run if the block stops making progress.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Probability values favor the corners: zero, full scale, tiny values and
    // single set bits, with plain random words for the rest.
    function automatic logic [PROB_W-1:0] pick_prob();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return PROB_W'($urandom_range(255));
            3:       return PROB_W'(1) << $urandom_range(PROB_W - 1);
            default: return $urandom;
        endcase
    endfunction

    // Offers one request and returns at the edge where it is accepted. The
    // valid line stays high into the next request unless a sender gap is drawn.
    task automatic push_request(
        input logic [ACTION_W-1:0] act,
        input logic [INDEX_W-1:0]  idx,
        input logic [PROB_W-1:0]   val,
        input logic [POOL_W-1:0]   pool,
        input logic [OBS_W-1:0]    obs
    );
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_action            <= act;
        i_state_index       <= idx;
        i_prob_value        <= val;
        i_pool_mask         <= pool;
        i_observed_response <= obs;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drops valid and waits until every predicted result has been taken.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Register write through a setup phase and an access phase, after which the bus is left idle.
    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Every entry is loaded once before anything is read or tested; loads
    // and tests only ever rewrite entries, so the table stays defined.
    task automatic fill_table();
        for (int st = 0; st < STATE_COUNT; st++) begin
            push_request(ACT_LOAD, INDEX_W'(st), pick_prob(), POOL_W'($urandom_range(15)),
                         OBS_W'($urandom_range(3)));
        end
    endtask

    // Tests are kept rare since each one walks the whole table and divides
    // every entry; the rest split between loads, reads and the unused action.
    // Fields that an action ignores are still randomized.
    task automatic random_request(input bit allow_test);
        int                  roll;
        logic [ACTION_W-1:0] act;
        roll = $urandom_range(99);
        if (allow_test && roll < 4) begin
            act = ACT_TEST;
        end else if (roll < 9) begin
            act = ACT_SPARE;
        end else if (roll < 50) begin
            act = ACT_LOAD;
        end else begin
            act = ACT_READ;
        end
        push_request(act, INDEX_W'($urandom_range(255)), pick_prob(),
                     POOL_W'($urandom_range(15)), OBS_W'($urandom_range(3)));
    endtask

    // Starts a phase from an idle block: weights and idling pattern.
    task automatic start_phase(
        input logic [PROB_W-1:0] mismatch,
        input logic [PROB_W-1:0] match,
        input int                tx_pct,
        input int                rx_pct
    );
        drain_results();
        apb_write(ADDR_MISMATCH, mismatch);
        apb_write(ADDR_MATCH, match);
        tx_idle_pct  = tx_pct;
        rx_stall_pct <= rx_pct;
    endtask

    initial begin : stimulus
        i_rst_n             <= 1'b0;
        i_in_valid          <= 1'b0;
        i_action            <= ACT_LOAD;
        i_state_index       <= '0;
        i_prob_value        <= '0;
        i_pool_mask         <= '0;
        i_observed_response <= '0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset weights, no idling. Directed requests first: table corners,
        // every action, the empty pool and the full pool.
        fill_table();
        push_request(ACT_READ, 8'd0, '0, '0, '0);
        push_request(ACT_READ, 8'd255, '1, '1, '1);
        push_request(ACT_LOAD, 8'd0, '0, '1, '1);
        push_request(ACT_LOAD, 8'd255, '1, '0, '0);
        push_request(ACT_READ, 8'd0, '0, '0, '0);
        push_request(ACT_READ, 8'd255, '0, '0, '0);
        push_request(ACT_SPARE, '1, '1, '1, '1);
        push_request(ACT_TEST, '0, '0, 4'b0000, 2'b00);
        push_request(ACT_READ, 8'd255, '0, '0, '0);
        push_request(ACT_TEST, '1, '1, 4'b1111, 2'b11);
        push_request(ACT_TEST, '0, '0, 4'b0101, 2'b10);
        push_request(ACT_READ, 8'd0, '0, '0, '0);
        repeat (150) random_request(1'b1);

        // Zero weights scale every entry to zero: the total is zero and the
        // table is left all zero.
        start_phase('0, '0, 74, 0);
        push_request(ACT_TEST, '0, '0, 4'b1001, 2'b10);
        push_request(ACT_READ, 8'h07, '0, '0, '0);

        // On the zeroed table a single live entry carries the whole total, so
        // its quotient overflows and must saturate.
        start_phase(MISMATCH_RESET, MATCH_RESET, 0, 74);
        push_request(ACT_LOAD, 8'h5A, 32'h8000_0000, '0, '0);
        push_request(ACT_TEST, '0, '0, 4'b0011, 2'b01);
        push_request(ACT_READ, 8'h5A, '0, '0, '0);
        push_request(ACT_READ, 8'h00, '0, '0, '0);

        // The receiver holds off for a long stretch while requests keep
        // coming, so the block backs up and stalls its input.
        hold_armed <= 1'b1;
        repeat (30) random_request(1'b0);
        repeat (150) random_request(1'b1);

        // Full-scale weights barely shrink the entries.
        start_phase('1, '1, 8, 8);
        repeat (150) random_request(1'b1);

        start_phase($urandom, $urandom, 74, 0);
        repeat (100) random_request(1'b1);

        // Zero weights again: every test ends with a zero total.
        start_phase('0, '0, 0, 0);
        repeat (80) random_request(1'b1);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
